>>> hw/rtl/nkmh_pkg.sv
// Shared types and constants for the nearest-k min-heap block.
// Used by the distance unit, the heap sequencer and the top level.
`timescale 1ns / 1ps
`default_nettype none
package nkmh_pkg;
    localparam int HEAP_DEPTH_DEF = 1024;
    localparam int MAX_K_DEF      = 64;
    localparam int LAT_W  = 30;
    localparam int LON_W  = 31;
    localparam int WANT_W = 7;
    localparam int KIND_W = 2;
    localparam int TAG_W  = 10;
    localparam int DIST_W = 63;

    localparam logic [KIND_W-1:0] KIND_BEGIN  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FINISH = 2'd2;
    // The remaining kind carries no operation and is ignored.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // Request from the sequencer to the shared distance unit.
    typedef struct packed {
        logic              start;
        logic [LAT_W-1:0]  lat;
        logic [LON_W-1:0]  lon;
    } dist_req_t;
endpackage
`default_nettype wire

>>> hw/rtl/nkmh_dist.sv
// Squared planar distance unit: one shared 32x32 squarer used twice.
// Depends on nkmh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nkmh_dist (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire nkmh_pkg::dist_req_t     req,
    input  wire [nkmh_pkg::LAT_W-1:0]    q_lat,
    input  wire [nkmh_pkg::LON_W-1:0]    q_lon,
    output logic                         done,
    output logic [nkmh_pkg::DIST_W-1:0]  dist_sq
);
    // Step 0: lat square, step 1: lon square, step 2: sum ready.
    logic [2:0]  step_reg, step_next;
    logic [31:0] dlat_reg, dlon_reg;
    logic [63:0] acc_reg;
    logic [31:0] sq_in;
    logic [63:0] sq_out;
    logic signed [31:0] dl, dn;

    assign dl = 32'(signed'(req.lat)) - 32'(signed'(q_lat));
    assign dn = 32'(signed'(req.lon)) - 32'(signed'(q_lon));
    assign sq_in  = step_reg[0] ? dlat_reg : dlon_reg;
    assign sq_out = 64'(sq_in) * 64'(sq_in);

    always_comb begin
        step_next = {step_reg[1:0], req.start};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
        end else begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            dlat_reg <= dl[31] ? 32'(-dl) : 32'(dl);
            dlon_reg <= dn[31] ? 32'(-dn) : 32'(dn);
            acc_reg  <= '0;
        end else if (step_reg[0] || step_reg[1]) begin
            acc_reg <= acc_reg + sq_out;
        end
    end

    assign done = step_reg[2];
    assign dist_sq = acc_reg[nkmh_pkg::DIST_W-1:0];
endmodule
`default_nettype wire

>>> hw/rtl/nkmh_heap.sv
// Heap sequencer: sift-up on load, sift-down pops on finish, one read and one write port.
// Depends on nkmh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nkmh_heap #(
    parameter int HEAP_DEPTH = nkmh_pkg::HEAP_DEPTH_DEF,
    parameter int MAX_K      = nkmh_pkg::MAX_K_DEF
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire [nkmh_pkg::KIND_W-1:0]   in_kind,
    input  wire [nkmh_pkg::LAT_W-1:0]    in_lat,
    input  wire [nkmh_pkg::LON_W-1:0]    in_lon,
    input  wire [nkmh_pkg::WANT_W-1:0]   in_want,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic [nkmh_pkg::TAG_W-1:0]   out_tag,
    output logic [nkmh_pkg::DIST_W-1:0]  out_dist,
    output logic                         out_last
);
    localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int KW = $clog2(MAX_K + 1);
    localparam int EW = nkmh_pkg::DIST_W + nkmh_pkg::TAG_W;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_DIST  = 11'b00000000010,
        S_UPRD  = 11'b00000000100,
        S_UPCMP = 11'b00000001000,
        S_ROOT  = 11'b00000010000,
        S_LAST  = 11'b00000100000,
        S_DNL   = 11'b00001000000,
        S_DNR   = 11'b00010000000,
        S_DNCMP = 11'b00100000000,
        S_EMIT  = 11'b01000000000,
        S_DNRW  = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic [EW-1:0] mem [HEAP_DEPTH];
    logic [EW-1:0] rd_reg;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;

    logic [CW-1:0] fill_reg, fill_next;
    logic [nkmh_pkg::TAG_W-1:0] total_reg, total_next;
    logic [nkmh_pkg::LAT_W-1:0] qlat_reg, qlat_next;
    logic [nkmh_pkg::LON_W-1:0] qlon_reg, qlon_next;
    logic [KW-1:0] left_reg, left_next;
    logic [CW-1:0] idx_reg, idx_next, child_reg, child_next;
    logic [EW-1:0] cur_reg, cur_next, lch_reg, lch_next, top_reg, top_next;
    logic          ov_reg, ov_next, last_reg, last_next;

    nkmh_pkg::dist_req_t dreq;
    logic        ddone;
    logic [nkmh_pkg::DIST_W-1:0] dval;

    nkmh_dist u_dist (
        .aclk(aclk), .aresetn(aresetn), .req(dreq), .q_lat(qlat_reg), .q_lon(qlon_reg),
        .done(ddone), .dist_sq(dval)
    );

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[rd_addr];
    end

    logic [CW-1:0] parent;
    logic [CW-1:0] idx2p1;
    logic [CW:0]   k_cap;
    assign parent = (idx_reg - CW'(1)) >> 1;
    assign idx2p1 = CW'({idx_reg, 1'b0} + 1);

    assign in_ready = (state_reg == S_IDLE);
    assign dreq.start = (state_reg == S_IDLE) && in_valid && in_kind == nkmh_pkg::KIND_LOAD
                        && fill_reg != CW'(HEAP_DEPTH);
    assign dreq.lat = in_lat;
    assign dreq.lon = in_lon;

    always_comb begin
        state_next = state_reg;
        fill_next = fill_reg; total_next = total_reg;
        qlat_next = qlat_reg; qlon_next = qlon_reg;
        left_next = left_reg; idx_next = idx_reg; child_next = child_reg;
        cur_next = cur_reg; lch_next = lch_reg; top_next = top_reg;
        ov_next = ov_reg; last_next = last_reg;
        rd_addr = '0; wr_en = 1'b0; wr_addr = '0; wr_data = cur_reg;
        k_cap = '0;
        if (ov_reg && out_ready) begin
            ov_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    case (in_kind)
                        nkmh_pkg::KIND_BEGIN: begin
                            qlat_next = in_lat; qlon_next = in_lon;
                            fill_next = '0; total_next = '0;
                        end
                        nkmh_pkg::KIND_LOAD: begin
                            if (dreq.start) state_next = S_DIST;
                        end
                        nkmh_pkg::KIND_FINISH: begin
                            k_cap = (CW+1)'(in_want);
                            if (k_cap > (CW+1)'(fill_reg)) k_cap = (CW+1)'(fill_reg);
                            if (k_cap > (CW+1)'(MAX_K)) k_cap = (CW+1)'(MAX_K);
                            left_next = KW'(k_cap);
                            if (k_cap != '0) state_next = S_ROOT;
                        end
                        default: ;
                    endcase
                end
            end
            S_DIST: begin
                if (ddone) begin
                    cur_next = {dval, total_reg};
                    idx_next = fill_reg;
                    fill_next = fill_reg + CW'(1);
                    total_next = total_reg + 1'b1;
                    state_next = S_UPRD;
                end
            end
            S_UPRD: begin
                if (idx_reg == '0) begin
                    wr_en = 1'b1; wr_addr = AW'(idx_reg);
                    state_next = S_IDLE;
                end else begin
                    rd_addr = AW'(parent);
                    state_next = S_UPCMP;
                end
            end
            S_UPCMP: begin
                if (rd_reg[EW-1:nkmh_pkg::TAG_W] > cur_reg[EW-1:nkmh_pkg::TAG_W]) begin
                    wr_en = 1'b1; wr_addr = AW'(idx_reg); wr_data = rd_reg;
                    idx_next = parent;
                    state_next = S_UPRD;
                end else begin
                    wr_en = 1'b1; wr_addr = AW'(idx_reg);
                    state_next = S_IDLE;
                end
            end
            S_ROOT: begin
                rd_addr = '0;
                if (!ov_reg || out_ready) state_next = S_LAST;
            end
            S_LAST: begin
                top_next = rd_reg;
                fill_next = fill_reg - CW'(1);
                rd_addr = AW'(fill_reg - CW'(1));
                idx_next = '0;
                state_next = S_DNL;
            end
            S_DNL: begin
                cur_next = rd_reg;
                if (idx2p1 < fill_reg) begin
                    rd_addr = AW'(idx2p1);
                    child_next = idx2p1;
                    state_next = S_DNR;
                end else begin
                    state_next = S_EMIT;
                end
            end
            S_DNR: begin
                lch_next = rd_reg;
                if (child_reg + CW'(1) < fill_reg) begin
                    rd_addr = AW'(child_reg + CW'(1));
                    state_next = S_DNRW;
                end else begin
                    state_next = S_DNCMP;
                end
            end
            S_DNRW: begin
                if (rd_reg[EW-1:nkmh_pkg::TAG_W] < lch_reg[EW-1:nkmh_pkg::TAG_W]) begin
                    lch_next = rd_reg;
                    child_next = child_reg + CW'(1);
                end
                state_next = S_DNCMP;
            end
            S_DNCMP: begin
                if (cur_reg[EW-1:nkmh_pkg::TAG_W] <= lch_reg[EW-1:nkmh_pkg::TAG_W]) begin
                    state_next = S_EMIT;
                end else begin
                    wr_en = 1'b1; wr_addr = AW'(idx_reg); wr_data = lch_reg;
                    idx_next = child_reg;
                    if (CW'({child_reg, 1'b0} + 1) < fill_reg) begin
                        rd_addr = AW'({child_reg, 1'b0} + 1);
                        child_next = CW'({child_reg, 1'b0} + 1);
                        state_next = S_DNR;
                    end else begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                wr_en = 1'b1; wr_addr = AW'(idx_reg); wr_data = cur_reg;
                ov_next = 1'b1;
                last_next = (left_reg == KW'(1));
                left_next = left_reg - KW'(1);
                state_next = (left_reg == KW'(1)) ? S_IDLE : S_ROOT;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            fill_reg <= '0; total_reg <= '0; qlat_reg <= '0; qlon_reg <= '0;
            ov_reg <= 1'b0; left_reg <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg <= fill_next; total_reg <= total_next;
            qlat_reg <= qlat_next; qlon_reg <= qlon_next;
            ov_reg <= ov_next; left_reg <= left_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next; child_reg <= child_next;
        cur_reg <= cur_next; lch_reg <= lch_next; top_reg <= top_next;
        last_reg <= last_next;
    end

    // The popped root is held in top_reg until the sift-down finishes.
    assign out_valid = ov_reg;
    assign out_tag   = top_reg[nkmh_pkg::TAG_W-1:0];
    assign out_dist  = top_reg[EW-1:nkmh_pkg::TAG_W];
    assign out_last  = last_reg;
endmodule
`default_nettype wire

>>> hw/rtl/nearest_k_min_heap.sv
// Nearest-k selector, top level: stream ports around the heap sequencer.
// Depends on nkmh_pkg and nkmh_heap (which holds nkmh_dist).
//
// Input transactions on s_axis: s_axis_tuser carries kind (0 begin query, 1 load
// point, 2 finish); s_axis_tdata carries coord_lat, coord_lon and want_count.
// A begin latches the query point and empties the heap.
// A load computes the distance (one shared squarer, used for latitude then
// longitude), then for each heap level climbed reads and compares the parent,
// and finally stores the entry in its place.
// A finish pops min(k, fill, MAX_K) entries; each pop reads the root, moves the
// last entry to the top and sifts it down, comparing one or both children per
// level. Results leave on m_axis, index and distance in m_axis_tdata, m_axis_tlast
// on the final one. s_axis_tready is low while an item is being worked on. A stall
// on m_axis holds the output register and pauses the next pop; nothing is lost.
// Reset clears fill count, load count and query point; heap memory needs no
// clearing since only live entries are read.
`timescale 1ns / 1ps
`default_nettype none
module nearest_k_min_heap #(
    parameter int HEAP_DEPTH = nkmh_pkg::HEAP_DEPTH_DEF,
    parameter int MAX_K      = nkmh_pkg::MAX_K_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [71:0]  s_axis_tdata,  // coord_lat[29:0], coord_lon[60:30], want_count[67:61]
    input  wire [1:0]   s_axis_tuser,  // kind[1:0]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [79:0] m_axis_tdata,  // point_index[9:0], dist_sq[72:10]
    output logic        m_axis_tlast
);
    logic [nkmh_pkg::TAG_W-1:0]  tag;
    logic [nkmh_pkg::DIST_W-1:0] dist_sq;

    nkmh_heap #(.HEAP_DEPTH(HEAP_DEPTH), .MAX_K(MAX_K)) u_heap (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_kind(s_axis_tuser), .in_lat(s_axis_tdata[29:0]),
        .in_lon(s_axis_tdata[60:30]), .in_want(s_axis_tdata[67:61]),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_tag(tag), .out_dist(dist_sq), .out_last(m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, dist_sq, tag};

    logic unused_ok;
    assign unused_ok = ^s_axis_tdata[71:68];
endmodule
`default_nettype wire

>>> hw/rtl/nkmh_checker.sv
// Port-level checker for nearest_k_min_heap, bound to the top level.
// Depends on the top level's ports and the kind codes in nkmh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nkmh_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire [1:0]  s_axis_tuser,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [79:0] m_axis_tdata,
    input wire        m_axis_tlast
);
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output changed while stalled");
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid && s_axis_tready)
        else $error("not idle after reset");
    a_begin_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == nkmh_pkg::KIND_BEGIN
            |=> s_axis_tready)
        else $error("begin should take one cycle");
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[79:73] == 7'd0)
        else $error("padding bits set");
endmodule

bind nearest_k_min_heap nkmh_checker u_nkmh_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire
